// ===== rtl/lottery_slot_scheduler_defines.svh =====
// Assertion macros shared by the lottery slot scheduler RTL.
`ifndef LOTTERY_SLOT_SCHEDULER_DEFINES_SVH
`define LOTTERY_SLOT_SCHEDULER_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define LSS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define LSS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lss_pkg.sv =====
// Shared constants, codes and types of the lottery slot scheduler.
`default_nettype none
package lss_pkg;

    localparam int NUM_SLOTS = 64;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);
    localparam int CMP_W     = (SLOT_W > 6) ? SLOT_W : 6;
    localparam int TK_W      = 10;
    localparam int TOT_W     = 16;
    localparam int RND_W     = 32;
    localparam int SUM_W     = $clog2(NUM_SLOTS * 1023 + 1);
    localparam int CNT_W     = $clog2(RND_W + 1);

    // Request codes
    localparam logic [1:0] REQ_DRAW  = 2'd0;
    localparam logic [1:0] REQ_ALLOC = 2'd1;
    localparam logic [1:0] REQ_SET   = 2'd2;

    // Result status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_FULL    = 2'd1;
    localparam logic [1:0] STAT_NOGRANT = 2'd2;

    // Slot life states
    localparam logic [2:0] SLOT_UNUSED   = 3'd0;
    localparam logic [2:0] SLOT_EMBRYO   = 3'd1;
    localparam logic [2:0] SLOT_RUNNABLE = 3'd3;
    localparam logic [2:0] SLOT_RUNNING  = 3'd4;
    localparam logic [2:0] SLOT_ZOMBIE   = 3'd5;

    localparam logic [TK_W-1:0] TICKETS_RESET = TK_W'(100);

    // Request token that travels down the slot chain
    typedef struct packed {
        logic              valid;
        logic [1:0]        op;
        logic              done;
        logic [1:0]        status;
        logic [SLOT_W-1:0] slot;
        logic [5:0]        set_idx;
        logic [2:0]        new_state;
        logic [TK_W-1:0]   alloc_tk;
        logic [SUM_W-1:0]  target;
        logic [SUM_W-1:0]  lo;
        logic [TK_W-1:0]   sub;
    } tok_t;

    // Start request to the remainder unit
    typedef struct packed {
        logic             start;
        logic [RND_W-1:0] dividend;
        logic [TOT_W-1:0] divisor;
    } mod_req_t;

endpackage
`default_nettype wire

// ===== rtl/lss_mod.sv =====
// Restoring remainder unit: one quotient bit per cycle.
`default_nettype none
module lss_mod (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire lss_pkg::mod_req_t       req,
    output logic                         done,
    output logic [lss_pkg::TOT_W-1:0]    rem
);
    import lss_pkg::*;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [RND_W-1:0] dvd_reg, dvd_next;
    logic [TOT_W-1:0] div_reg, div_next;
    logic [TOT_W-1:0] rem_reg, rem_next;
    logic [TOT_W:0]   shifted;

    // Shift in one dividend bit and subtract when it fits
    always_comb begin
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, dvd_reg[RND_W-1]};
        if (req.start) begin
            cnt_next = CNT_W'(RND_W);
            dvd_next = req.dividend;
            div_next = req.divisor;
            rem_next = '0;
        end else if (cnt_reg != '0) begin
            cnt_next = cnt_reg - CNT_W'(1);
            dvd_next = {dvd_reg[RND_W-2:0], 1'b0};
            if (shifted >= {1'b0, div_reg}) begin
                rem_next = TOT_W'(shifted - {1'b0, div_reg});
            end else begin
                rem_next = TOT_W'(shifted);
            end
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule
`default_nettype wire

// ===== rtl/lss_cell.sv =====
// One slot cell: holds a slot's state and tickets and acts on the passing token.
`default_nettype none
module lss_cell (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic [lss_pkg::SLOT_W-1:0] cell_idx,
    input  wire lss_pkg::tok_t              tok_i,
    output lss_pkg::tok_t                   tok_o
);
    import lss_pkg::*;

    logic [2:0]       state_reg, state_next;
    logic [TK_W-1:0]  tk_reg, tk_next;
    tok_t             tok_reg, tok_next;
    logic             live;
    logic [SUM_W-1:0] hi;

    assign live = (state_reg != SLOT_UNUSED) && (state_reg != SLOT_ZOMBIE);
    assign hi   = tok_i.lo + SUM_W'(tk_reg);

    // Apply the token to this slot and pass it on
    always_comb begin
        state_next = state_reg;
        tk_next    = tk_reg;
        tok_next   = tok_i;
        if (tok_i.valid) begin
            unique case (tok_i.op)
                REQ_ALLOC: begin
                    if (!tok_i.done && state_reg == SLOT_UNUSED) begin
                        state_next      = SLOT_EMBRYO;
                        tk_next         = tok_i.alloc_tk;
                        tok_next.done   = 1'b1;
                        tok_next.status = STAT_OK;
                        tok_next.slot   = cell_idx;
                    end
                end
                REQ_SET: begin
                    if (CMP_W'(tok_i.set_idx) == CMP_W'(cell_idx)
                        && tok_i.new_state <= SLOT_ZOMBIE) begin
                        if (tok_i.new_state == SLOT_ZOMBIE && live) begin
                            tok_next.sub = tk_reg;
                        end
                        state_next = tok_i.new_state;
                    end
                end
                REQ_DRAW: begin
                    if (!tok_i.done && live) begin
                        if (tok_i.target < hi) begin
                            tok_next.done = 1'b1;
                            if (state_reg == SLOT_RUNNABLE) begin
                                state_next      = SLOT_RUNNING;
                                tok_next.status = STAT_OK;
                                tok_next.slot   = cell_idx;
                            end else begin
                                tok_next.status = STAT_NOGRANT;
                            end
                        end else begin
                            tok_next.lo = hi;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SLOT_UNUSED;
            tk_reg    <= '0;
            tok_reg   <= '0;
        end else begin
            state_reg <= state_next;
            tk_reg    <= tk_next;
            tok_reg   <= tok_next;
        end
    end

    assign tok_o = tok_reg;

endmodule
`default_nettype wire

// ===== rtl/lss_chain.sv =====
// Row of slot cells; the token advances one cell per cycle.
`default_nettype none
module lss_chain (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire lss_pkg::tok_t tok_i,
    output lss_pkg::tok_t      tok_o
);
    import lss_pkg::*;

    tok_t link [NUM_SLOTS+1];

    assign link[0] = tok_i;

    // Build the row of cells
    for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
        lss_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_idx (SLOT_W'(g)),
            .tok_i    (link[g]),
            .tok_o    (link[g+1])
        );
    end

    assign tok_o = link[NUM_SLOTS];

endmodule
`default_nettype wire

// ===== rtl/lottery_slot_scheduler.sv =====
// Top level of the lottery slot scheduler: request sequencing, total and result register.
//
//  Channel   Direction  Handshake          Payload
//  s_        in         s_tvalid/s_tready  s_tuser: req_type; s_tdata: index, state, random
//  m_        out        m_tvalid/m_tready  m_tuser: status; m_tdata: slot, total tickets
//  cfg_      in         cfg_wen            cfg_wdata: tickets_per_slot
//
// One request at a time. Allocate, set state and unknown requests walk the token through
// the cell row, one cell per cycle; a draw with a nonzero total first runs the bit-serial
// remainder. Reset clears all slots to unused with zero tickets, the total to zero and
// tickets_per_slot to 100; no clearing pass. A stalled result waits in the output
// register while the next request is already accepted.
`default_nettype none
`include "lottery_slot_scheduler_defines.svh"
module lottery_slot_scheduler (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // [5:0] slot_index, [8:6] new_state,
                                        // [40:9] random_value, rest zero
    input  wire logic [1:0]  s_tuser,   // [1:0] req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [5:0] slot_out, [21:6] total_tickets_out,
                                        // rest zero
    output logic [1:0]       m_tuser,   // [1:0] status
    input  wire logic        cfg_wen,
    input  wire logic [9:0]  cfg_wdata
);
    import lss_pkg::*;

    localparam logic [2:0] FSM_IDLE = 3'd0;
    localparam logic [2:0] FSM_MOD  = 3'd1;
    localparam logic [2:0] FSM_LOAD = 3'd2;
    localparam logic [2:0] FSM_WALK = 3'd3;
    localparam logic [2:0] FSM_DONE = 3'd4;

    logic [2:0]        fsm_reg, fsm_next;
    logic [TK_W-1:0]   tps_reg;
    logic [TOT_W-1:0]  total_reg, total_next;
    logic [1:0]        req_reg;
    logic [5:0]        idx_reg;
    logic [2:0]        ns_reg;
    logic [1:0]        res_status_reg, res_status_next;
    logic [5:0]        res_slot_reg, res_slot_next;
    logic              m_tvalid_reg;
    logic [1:0]        m_status_reg;
    logic [5:0]        m_slot_reg;
    logic [TOT_W-1:0]  m_total_reg;

    logic              s_fire;
    logic              out_free;
    mod_req_t          mod_req;
    logic              mod_done;
    logic [TOT_W-1:0]  mod_rem;
    tok_t              tok_in;
    tok_t              tok_out;
    logic [TOT_W:0]    alloc_sum;
    logic [CMP_W-1:0]  slot_wide;

    assign s_tready = (fsm_reg == FSM_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Start the remainder on a draw with a nonzero total
    assign mod_req.start    = s_fire && (s_tuser == REQ_DRAW) && (total_reg != '0);
    assign mod_req.dividend = s_tdata[40:9];
    assign mod_req.divisor  = total_reg;

    lss_mod u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mod_req),
        .done    (mod_done),
        .rem     (mod_rem)
    );

    // Build the token injected into the cell row
    always_comb begin
        tok_in           = '0;
        tok_in.valid     = (fsm_reg == FSM_LOAD);
        tok_in.op        = req_reg;
        tok_in.set_idx   = idx_reg;
        tok_in.new_state = ns_reg;
        tok_in.alloc_tk  = tps_reg;
        tok_in.target    = SUM_W'(mod_rem);
        tok_in.status    = STAT_OK;
        case (req_reg)
            REQ_DRAW: begin
                if (total_reg == '0) begin
                    tok_in.done   = 1'b1;
                    tok_in.status = STAT_NOGRANT;
                end
            end
            REQ_ALLOC: tok_in.done = 1'b0;
            default:   tok_in.done = 1'b1;
        endcase
    end

    lss_chain u_chain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tok_i   (tok_in),
        .tok_o   (tok_out)
    );

    assign alloc_sum = {1'b0, total_reg} + (TOT_W+1)'(tps_reg);
    assign slot_wide = CMP_W'(tok_out.slot);

    // Close out the request when the token leaves the row
    always_comb begin
        total_next      = total_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        if (fsm_reg == FSM_WALK && tok_out.valid) begin
            if (tok_out.done) begin
                res_status_next = tok_out.status;
                res_slot_next   = (tok_out.status == STAT_OK) ? slot_wide[5:0] : 6'd0;
            end else begin
                res_status_next = (tok_out.op == REQ_ALLOC) ? STAT_FULL : STAT_NOGRANT;
                res_slot_next   = 6'd0;
            end
            if (tok_out.op == REQ_ALLOC && tok_out.done) begin
                total_next = alloc_sum[TOT_W] ? '1 : alloc_sum[TOT_W-1:0];
            end else if (tok_out.op == REQ_SET) begin
                total_next = (TOT_W'(tok_out.sub) >= total_reg) ? '0
                           : total_reg - TOT_W'(tok_out.sub);
            end
        end
    end

    // Sequence one request at a time
    always_comb begin
        fsm_next = fsm_reg;
        unique case (fsm_reg)
            FSM_IDLE: begin
                if (s_fire) begin
                    fsm_next = mod_req.start ? FSM_MOD : FSM_LOAD;
                end
            end
            FSM_MOD:  if (mod_done) fsm_next = FSM_LOAD;
            FSM_LOAD: fsm_next = FSM_WALK;
            FSM_WALK: if (tok_out.valid) fsm_next = FSM_DONE;
            FSM_DONE: if (out_free) fsm_next = FSM_IDLE;
            default:  fsm_next = FSM_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg      <= FSM_IDLE;
            tps_reg      <= TICKETS_RESET;
            total_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            fsm_reg   <= fsm_next;
            total_reg <= total_next;
            if (cfg_wen) begin
                tps_reg <= cfg_wdata;
            end
            // Hand the result to the output register, drop it once taken
            if (fsm_reg == FSM_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
        // Hold the accepted request fields
        if (s_fire) begin
            req_reg <= s_tuser;
            idx_reg <= s_tdata[5:0];
            ns_reg  <= s_tdata[8:6];
        end
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        if (fsm_reg == FSM_DONE && out_free) begin
            m_status_reg <= res_status_reg;
            m_slot_reg   <= res_slot_reg;
            m_total_reg  <= total_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {2'b00, m_total_reg, m_slot_reg};

    `LSS_ASSERT_NXT(a_one_at_a_time, s_fire, !s_tready, "request accepted while busy")
    `LSS_ASSERT_IMP(a_token_in_walk, tok_out.valid, fsm_reg == FSM_WALK,
                    "token left the cell row outside the walk")
    `LSS_ASSERT_IMP(a_mod_in_mod, mod_done, fsm_reg == FSM_MOD,
                    "remainder finished outside its state")
    `LSS_ASSERT_IMP(a_slot_zero, m_tvalid && m_tuser != STAT_OK, m_tdata[5:0] == 6'd0,
                    "slot reported without a grant")

endmodule
`default_nettype wire

// ===== verif/lottery_slot_scheduler_tb.sv =====
// Self-checking testbench for the lottery slot scheduler: directed and random requests.
`timescale 1ns / 100ps

import lss_pkg::*;

typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  slot;
    logic [15:0] total;
} sched_outcome_t;

// Track slot states, tickets and the live total; hold the outcomes still owed by the block
class lottery_ledger;
    logic [2:0]     slot_st [NUM_SLOTS];
    logic [9:0]     slot_tk [NUM_SLOTS];
    int unsigned    total;
    logic [9:0]     grant_tk;
    sched_outcome_t outcome_q [$];
    int             errors;

    function new();
        for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_st[i] = SLOT_UNUSED;
            slot_tk[i] = '0;
        end
        total    = 0;
        grant_tk = TICKETS_RESET;
        errors   = 0;
    endfunction

    function void set_grant(logic [9:0] tk);
        grant_tk = tk;
    endfunction

    function int pending();
        return outcome_q.size();
    endfunction

    function bit is_live(logic [2:0] st);
        return st != SLOT_UNUSED && st != SLOT_ZOMBIE;
    endfunction

    // Apply one accepted request and queue the outcome it must produce
    function void record_request(logic [1:0] req, logic [5:0] idx, logic [2:0] ns,
                                 logic [31:0] rnd);
        sched_outcome_t res;
        int unsigned    target;
        int unsigned    lo;
        int unsigned    hi;
        bit             found;
        res.status = STAT_OK;
        res.slot   = '0;
        found      = 1'b0;
        case (req)
            REQ_ALLOC: begin
                res.status = STAT_FULL;
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (!found && slot_st[i] == SLOT_UNUSED) begin
                        found      = 1'b1;
                        slot_st[i] = SLOT_EMBRYO;
                        slot_tk[i] = grant_tk;
                        total      = total + grant_tk;
                        if (total > 65535)
                            total = 65535;
                        res.status = STAT_OK;
                        res.slot   = i[5:0];
                    end
                end
            end
            REQ_SET: begin
                // states above zombie leave the slot alone
                if (ns <= SLOT_ZOMBIE) begin
                    if (ns == SLOT_ZOMBIE && is_live(slot_st[idx]))
                        total = (slot_tk[idx] >= total) ? 0 : total - slot_tk[idx];
                    slot_st[idx] = ns;
                end
            end
            REQ_DRAW: begin
                res.status = STAT_NOGRANT;
                if (total != 0) begin
                    target = rnd % total;
                    lo     = 0;
                    // walk live slots in index order; the range holding target decides
                    for (int i = 0; i < NUM_SLOTS; i++) begin
                        if (!found && is_live(slot_st[i])) begin
                            hi = lo + slot_tk[i];
                            if (target >= lo && target < hi) begin
                                found = 1'b1;
                                if (slot_st[i] == SLOT_RUNNABLE) begin
                                    slot_st[i] = SLOT_RUNNING;
                                    res.status = STAT_OK;
                                    res.slot   = i[5:0];
                                end
                            end
                            lo = hi;
                        end
                    end
                end
            end
            default: ;
        endcase
        res.total = total[15:0];
        outcome_q.push_back(res);
    endfunction

    function void flag(string what, int unsigned exp_v, int unsigned act_v);
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, act_v);
    endfunction

    // Compare one result transfer against the oldest outstanding outcome
    function void check_outcome(logic [1:0] st, logic [5:0] sl, logic [15:0] tot);
        sched_outcome_t exp_r;
        if (outcome_q.size() == 0) begin
            errors++;
            $display("%0t: result with nothing outstanding, status %0d slot %0d total %0d",
                     $time, st, sl, tot);
            return;
        end
        exp_r = outcome_q.pop_front();
        if (st !== exp_r.status)
            flag("status", exp_r.status, st);
        if (sl !== exp_r.slot)
            flag("slot_out", exp_r.slot, sl);
        if (tot !== exp_r.total)
            flag("total_tickets_out", exp_r.total, tot);
    endfunction
endclass

module lottery_slot_scheduler_tb;

    localparam logic [1:0] REQ_NONE      = 2'd3;
    localparam logic [2:0] SLOT_SLEEPING = 3'd2;
    localparam logic [2:0] STATE_BAD_LO  = 3'd6;
    localparam logic [2:0] STATE_BAD_HI  = 3'd7;
    localparam int         STALL_LIMIT   = 3000;
    localparam int         HOLD_CYCLES   = 400;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_wen   = 1'b0;
    logic [9:0]  cfg_wdata = '0;

    logic        no_gaps   = 1'b0;
    logic        sink_hold = 1'b0;
    int unsigned sink_wait = 0;

    lottery_ledger ledger = new;

    lottery_slot_scheduler u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int unsigned pick_gap();
        return no_gaps ? 0 : $urandom_range(0, 15);
    endfunction

    // Result side: check each transfer, then back off for a random number of cycles
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            sink_wait = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                ledger.check_outcome(m_tuser, m_tdata[5:0], m_tdata[21:6]);
                sink_wait = pick_gap();
            end else if (sink_wait != 0) begin
                sink_wait--;
            end
            m_tready <= (sink_wait == 0) && !sink_hold;
        end
    end

    // Abort when neither channel moves for too long
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle = 0;
            else
                idle++;
        end
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    // Offer one request after a random gap and hold it until the block takes it
    task automatic send_request(input logic [1:0] req, input logic [5:0] idx,
                                input logic [2:0] ns, input logic [31:0] rnd);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {7'b0, rnd, ns, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        ledger.record_request(req, idx, ns, rnd);
    endtask

    // Random request: mostly allocate, set and draw, with favored states and slots
    task automatic send_random();
        int unsigned pick;
        logic [1:0]  req;
        logic [5:0]  idx;
        logic [2:0]  ns;
        logic [31:0] rnd;
        pick = $urandom_range(0, 99);
        if (pick < 25)
            req = REQ_ALLOC;
        else if (pick < 60)
            req = REQ_SET;
        else if (pick < 96)
            req = REQ_DRAW;
        else
            req = REQ_NONE;
        idx  = $urandom_range(0, 1) ? 6'($urandom_range(0, 15)) : 6'($urandom_range(0, 63));
        pick = $urandom_range(0, 99);
        if (pick < 38)
            ns = SLOT_RUNNABLE;
        else if (pick < 53)
            ns = SLOT_ZOMBIE;
        else if (pick < 68)
            ns = SLOT_UNUSED;
        else if (pick < 78)
            ns = SLOT_SLEEPING;
        else if (pick < 86)
            ns = SLOT_RUNNING;
        else if (pick < 94)
            ns = SLOT_EMBRYO;
        else
            ns = $urandom_range(0, 1) ? STATE_BAD_LO : STATE_BAD_HI;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            rnd = $urandom;
        else if (pick < 85)
            rnd = $urandom_range(0, 2000);
        else
            rnd = 32'hFFFF_FFFF - $urandom_range(0, 2000);
        send_request(req, idx, ns, rnd);
    endtask

    // Drop valid and wait until every outstanding result has been taken
    task automatic drain();
        s_tvalid <= 1'b0;
        while (ledger.pending() != 0) @(posedge aclk);
    endtask

    task automatic write_tickets(input logic [9:0] tk);
        @(posedge aclk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= tk;
        @(posedge aclk);
        cfg_wen   <= 1'b0;
        ledger.set_grant(tk);
    endtask

    // Stall the result side for a long stretch so the block backs up its input
    task automatic hold_results(input int cycles);
        @(posedge aclk);
        sink_hold <= 1'b1;
        repeat (cycles) @(posedge aclk);
        sink_hold <= 1'b0;
    endtask

    // Retire every slot through zombie back to unused
    task automatic clear_table();
        for (int i = 0; i < NUM_SLOTS; i++) begin
            send_request(REQ_SET, 6'(i), SLOT_ZOMBIE, $urandom);
            send_request(REQ_SET, 6'(i), SLOT_UNUSED, $urandom);
        end
    endtask

    initial begin : stimulus
        logic [9:0] phase_tk [6];
        phase_tk[0] = 10'd1;
        phase_tk[1] = 10'd1023;
        phase_tk[2] = 10'($urandom_range(1, 1023));
        phase_tk[3] = 10'($urandom_range(1, 7));
        phase_tk[4] = 10'd512;
        phase_tk[5] = 10'($urandom_range(1, 1023));

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: default ticket grant, empty draw, unknown request, invalid states,
        // zombie accounting with revive and floor, reuse, draw outside every live range
        send_request(REQ_DRAW,  6'd0,  SLOT_UNUSED,   32'd0);
        send_request(REQ_NONE,  6'd63, STATE_BAD_HI,  32'hFFFF_FFFF);
        send_request(REQ_ALLOC, 6'd0,  SLOT_UNUSED,   32'd0);
        send_request(REQ_ALLOC, 6'd0,  SLOT_UNUSED,   32'd0);
        send_request(REQ_ALLOC, 6'd0,  SLOT_UNUSED,   32'd0);
        send_request(REQ_SET,   6'd1,  SLOT_RUNNABLE, 32'd0);
        send_request(REQ_SET,   6'd2,  STATE_BAD_LO,  32'd0);
        send_request(REQ_SET,   6'd2,  STATE_BAD_HI,  32'd0);
        send_request(REQ_DRAW,  6'd0,  SLOT_UNUSED,   32'd0);
        send_request(REQ_DRAW,  6'd0,  SLOT_UNUSED,   32'd100);
        send_request(REQ_DRAW,  6'd0,  SLOT_UNUSED,   32'hFFFF_FFFF);
        send_request(REQ_SET,   6'd2,  SLOT_RUNNABLE, 32'd0);
        send_request(REQ_DRAW,  6'd0,  SLOT_UNUSED,   32'd250);
        send_request(REQ_SET,   6'd0,  SLOT_ZOMBIE,   32'd0);
        send_request(REQ_SET,   6'd0,  SLOT_ZOMBIE,   32'd0);
        send_request(REQ_SET,   6'd0,  SLOT_RUNNABLE, 32'd0);
        send_request(REQ_SET,   6'd63, SLOT_RUNNABLE, 32'd0);
        send_request(REQ_SET,   6'd1,  SLOT_ZOMBIE,   32'd0);
        send_request(REQ_SET,   6'd2,  SLOT_ZOMBIE,   32'd0);
        send_request(REQ_SET,   6'd0,  SLOT_ZOMBIE,   32'd0);
        send_request(REQ_SET,   6'd63, SLOT_UNUSED,   32'd0);
        send_request(REQ_ALLOC, 6'd0,  SLOT_UNUSED,   32'd0);
        send_request(REQ_SET,   6'd3,  SLOT_UNUSED,   32'd0);
        send_request(REQ_DRAW,  6'd0,  SLOT_UNUSED,   32'd50);

        // fill the table at the top grant, then reuse slots until the total saturates
        drain();
        write_tickets(10'd1023);
        repeat (NUM_SLOTS + 2) send_request(REQ_ALLOC, 6'($urandom), 3'($urandom), $urandom);
        for (int i = 10; i < 14; i++) begin
            send_request(REQ_SET, 6'(i), SLOT_UNUSED, $urandom);
            send_request(REQ_ALLOC, 6'($urandom), 3'($urandom), $urandom);
        end
        repeat (4) send_request(REQ_DRAW, 6'($urandom), 3'($urandom), $urandom);

        // random phases, each under its own ticket grant
        for (int p = 0; p < 6; p++) begin
            drain();
            write_tickets(phase_tk[p]);
            no_gaps <= (p == 3);
            if (p == 1) begin
                fork
                    hold_results(HOLD_CYCLES);
                    repeat (40) send_random();
                join
                repeat (130) send_random();
            end else begin
                repeat (170) send_random();
            end
            if (p % 2 == 1)
                clear_table();
        end

        drain();
        repeat (150) @(posedge aclk);
        if (ledger.pending() != 0) begin
            ledger.errors++;
            $display("%0t: %0d results never arrived", $time, ledger.pending());
        end
        if (ledger.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/lss_pkg.sv
rtl/lss_mod.sv
rtl/lss_cell.sv
rtl/lss_chain.sv
rtl/lottery_slot_scheduler.sv
verif/lottery_slot_scheduler_tb.sv
